// ----- rtl/address_range_decoder_with_fault_latch_defines.svh -----
// assertion macros shared by the checker
`ifndef ADDRESS_RANGE_DECODER_WITH_FAULT_LATCH_DEFINES_SVH
`define ADDRESS_RANGE_DECODER_WITH_FAULT_LATCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ADRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ADRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/adrd_pkg.sv -----
`default_nettype none
package adrd_pkg;

	localparam int ADDR_W   = 32;
	localparam int TARGET_W = 8;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 4;

	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TAKE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

	localparam logic [STATUS_W-1:0] ST_HIT      = 4'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED = 4'd1;
	localparam logic [STATUS_W-1:0] ST_ADDED    = 4'd2;
	localparam logic [STATUS_W-1:0] ST_BAD      = 4'd3;
	localparam logic [STATUS_W-1:0] ST_DUP      = 4'd4;
	localparam logic [STATUS_W-1:0] ST_FULL     = 4'd5;
	localparam logic [STATUS_W-1:0] ST_TAKEN    = 4'd6;
	localparam logic [STATUS_W-1:0] ST_NONE     = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 4'd8;

	localparam logic REG_DEV_START = 1'b0;
	localparam logic REG_FAULT_EN  = 1'b1;

	typedef struct packed {
		logic                hit;
		logic                dup;
		logic                full;
		logic                cache_cov;
		logic [TARGET_W-1:0] hit_target;
		logic [TARGET_W-1:0] cache_target;
	} adrd_lookup_t;

	typedef struct packed {
		logic add;
		logic clear;
	} adrd_update_t;

	typedef struct packed {
		logic                fault_write;
		logic [ADDR_W-1:0]   fault_address;
		logic                fault_raised;
		logic [TARGET_W-1:0] selected_target;
		logic [STATUS_W-1:0] status;
	} adrd_result_t;

endpackage
`default_nettype wire

// ----- rtl/adrd_table.sv -----
`default_nettype none
module adrd_table #(
	parameter int RANGE_ENTRIES = 16
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  adrd_pkg::adrd_update_t                     upd,
	input  wire  [adrd_pkg::ADDR_W-1:0]                address,
	input  wire  [adrd_pkg::ADDR_W-1:0]                range_end,
	input  wire  [adrd_pkg::TARGET_W-1:0]              target_id,
	input  wire  [$clog2(RANGE_ENTRIES)-1:0]           cache_slot,
	output adrd_pkg::adrd_lookup_t                     lookup,
	output logic [$clog2(RANGE_ENTRIES)-1:0]           hit_slot
);
	import adrd_pkg::*;

	localparam int SLOT_W = $clog2(RANGE_ENTRIES);
	localparam int LEAVES = 1 << SLOT_W;

	logic [ADDR_W-1:0]        start_q  [RANGE_ENTRIES];
	logic [ADDR_W-1:0]        last_q   [RANGE_ENTRIES];
	logic [TARGET_W-1:0]      target_q [RANGE_ENTRIES];
	logic [RANGE_ENTRIES-1:0] valid_q;

	logic [RANGE_ENTRIES-1:0] match;
	logic [RANGE_ENTRIES-1:0] same_start;
	logic [SLOT_W-1:0]        free_slot;

	logic                node_v     [2*LEAVES];
	logic [ADDR_W-1:0]   node_start [2*LEAVES];
	logic [SLOT_W-1:0]   node_idx   [2*LEAVES];

	always_comb begin
		for (int i = 0; i < RANGE_ENTRIES; i++) begin
			match[i] = valid_q[i] && (address >= start_q[i]) && (address <= last_q[i]);
			same_start[i] = valid_q[i] && (start_q[i] == address);
		end
	end

	// lowest free entry
	always_comb begin
		free_slot = '0;
		for (int i = RANGE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	// min tree on start over matching entries
	always_comb begin
		for (int i = 0; i < 2 * LEAVES; i++) begin
			node_v[i]     = 1'b0;
			node_start[i] = '0;
			node_idx[i]   = '0;
		end
		for (int i = 0; i < RANGE_ENTRIES; i++) begin
			node_v[LEAVES+i]     = match[i];
			node_start[LEAVES+i] = start_q[i];
			node_idx[LEAVES+i]   = SLOT_W'(i);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (node_v[2*n] && (!node_v[2*n+1] || node_start[2*n] <= node_start[2*n+1])) begin
				node_v[n]     = 1'b1;
				node_start[n] = node_start[2*n];
				node_idx[n]   = node_idx[2*n];
			end else begin
				node_v[n]     = node_v[2*n+1];
				node_start[n] = node_start[2*n+1];
				node_idx[n]   = node_idx[2*n+1];
			end
		end
	end

	assign hit_slot            = node_idx[1];
	assign lookup.hit          = node_v[1];
	assign lookup.hit_target   = target_q[node_idx[1]];
	assign lookup.dup          = |same_start;
	assign lookup.full         = &valid_q;
	assign lookup.cache_cov    = match[cache_slot];
	assign lookup.cache_target = target_q[cache_slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.clear) begin
			valid_q <= '0;
		end else if (upd.add) begin
			valid_q[free_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.add) begin
			start_q[free_slot]  <= address;
			last_q[free_slot]   <= range_end;
			target_q[free_slot] <= target_id;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/adrd_exec.sv -----
`default_nettype none
module adrd_exec #(
	parameter int RANGE_ENTRIES = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  fire,
	input  wire  [adrd_pkg::CMD_W-1:0]           command,
	input  wire  [adrd_pkg::ADDR_W-1:0]          address,
	input  wire  [adrd_pkg::ADDR_W-1:0]          range_end,
	input  wire  [adrd_pkg::ADDR_W-1:0]          device_space_start,
	input  wire                                  faults_enabled,
	input  adrd_pkg::adrd_lookup_t               lookup,
	input  wire  [$clog2(RANGE_ENTRIES)-1:0]     hit_slot,
	output logic [$clog2(RANGE_ENTRIES)-1:0]     cache_slot,
	output adrd_pkg::adrd_update_t               upd,
	output adrd_pkg::adrd_result_t               result
);
	import adrd_pkg::*;

	localparam int SLOT_W = $clog2(RANGE_ENTRIES);

	logic [SLOT_W-1:0] cache_slot_q;
	logic              cache_valid_q;
	logic              fault_pending_q;
	logic [ADDR_W-1:0] fault_address_q;
	logic              fault_write_q;

	logic add_ok;
	logic clear_ok;
	logic cache_fill;
	logic fault_set;
	logic fault_take;

	assign cache_slot = cache_slot_q;

	always_comb begin
		add_ok     = 1'b0;
		clear_ok   = 1'b0;
		cache_fill = 1'b0;
		fault_set  = 1'b0;
		fault_take = 1'b0;
		result     = '0;
		result.status = ST_NONE;
		case (command)
			CMD_ADD: begin
				if (address > range_end) begin
					result.status = ST_BAD;
				end else if (lookup.dup) begin
					result.status = ST_DUP;
				end else if (lookup.full) begin
					result.status = ST_FULL;
				end else begin
					result.status = ST_ADDED;
					add_ok = 1'b1;
				end
			end
			CMD_READ, CMD_WRITE, CMD_PEEK: begin
				if (command == CMD_READ && cache_valid_q && lookup.cache_cov) begin
					result.status          = ST_HIT;
					result.selected_target = lookup.cache_target;
				end else if (lookup.hit) begin
					result.status          = ST_HIT;
					result.selected_target = lookup.hit_target;
					cache_fill             = (command == CMD_READ);
				end else begin
					result.status = ST_UNMAPPED;
					if (command != CMD_PEEK && address >= device_space_start
							&& faults_enabled) begin
						fault_set           = 1'b1;
						result.fault_raised = 1'b1;
					end
				end
			end
			CMD_TAKE: begin
				if (fault_pending_q) begin
					result.status        = ST_TAKEN;
					result.fault_address = fault_address_q;
					result.fault_write   = fault_write_q;
					fault_take           = 1'b1;
				end
			end
			CMD_CLEAR: begin
				result.status = ST_CLEARED;
				clear_ok      = 1'b1;
			end
			default: begin
				result.status = ST_NONE;
			end
		endcase
	end

	assign upd.add   = fire && add_ok;
	assign upd.clear = fire && clear_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_slot_q    <= '0;
			cache_valid_q   <= 1'b0;
			fault_pending_q <= 1'b0;
			fault_address_q <= '0;
			fault_write_q   <= 1'b0;
		end else if (fire) begin
			if (clear_ok) begin
				cache_valid_q <= 1'b0;
			end else if (cache_fill) begin
				cache_slot_q  <= hit_slot;
				cache_valid_q <= 1'b1;
			end
			if (fault_set) begin
				fault_pending_q <= 1'b1;
				fault_address_q <= address;
				fault_write_q   <= (command == CMD_WRITE);
			end else if (fault_take) begin
				fault_pending_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/address_range_decoder_with_fault_latch.sv -----
// Bus address decoder with a table of RANGE_ENTRIES inclusive ranges and a
// latch for the last unmapped device access. Each input beat carries a
// command (add range, read, write, peek, take fault, clear table); each
// produces exactly one result beat. One beat is accepted every clock while
// the result side is not stalled; the result beat passes through the input
// register, then the result register, with all range compares and the
// lowest-start pick done in parallel in the single stage between them.
// Config writes (device space start, fault enable) take effect on the next
// cycle and are meant for idle periods. No clearing pass is needed after
// reset.
`default_nettype none
module address_range_decoder_with_fault_latch #(
	parameter int RANGE_ENTRIES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], address[34:3], range_end[66:35], target_id[74:67], zero pad
	input  wire  [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// status[3:0], selected_target[11:4], fault_raised[12],
	// fault_address_out[44:13], fault_write_out[45], zero pad
	output logic [47:0] m_axis_tdata,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);
	import adrd_pkg::*;

	localparam int SLOT_W = $clog2(RANGE_ENTRIES);

	logic                valid_s1;
	logic [CMD_W-1:0]    command_s1;
	logic [ADDR_W-1:0]   address_s1;
	logic [ADDR_W-1:0]   range_end_s1;
	logic [TARGET_W-1:0] target_id_s1;

	logic                out_valid_q;
	adrd_result_t        result_q;

	logic [ADDR_W-1:0]   dev_start_q;
	logic                fault_en_q;

	logic                in_fire;
	logic                advance;
	adrd_lookup_t        lookup;
	adrd_update_t        upd;
	adrd_result_t        result;
	logic [SLOT_W-1:0]   hit_slot;
	logic [SLOT_W-1:0]   cache_slot;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, result_q.fault_write, result_q.fault_address,
		result_q.fault_raised, result_q.selected_target, result_q.status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_start_q <= '0;
			fault_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEV_START: dev_start_q <= cfg_data;
				REG_FAULT_EN:  fault_en_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			command_s1   <= s_axis_tdata[2:0];
			address_s1   <= s_axis_tdata[34:3];
			range_end_s1 <= s_axis_tdata[66:35];
			target_id_s1 <= s_axis_tdata[74:67];
		end
		if (advance) begin
			result_q <= result;
		end
	end

	adrd_table #(
		.RANGE_ENTRIES(RANGE_ENTRIES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.address    (address_s1),
		.range_end  (range_end_s1),
		.target_id  (target_id_s1),
		.cache_slot (cache_slot),
		.lookup     (lookup),
		.hit_slot   (hit_slot)
	);

	adrd_exec #(
		.RANGE_ENTRIES(RANGE_ENTRIES)
	) u_exec (
		.clk                (clk),
		.arst_n             (arst_n),
		.fire               (advance),
		.command            (command_s1),
		.address            (address_s1),
		.range_end          (range_end_s1),
		.device_space_start (dev_start_q),
		.faults_enabled     (fault_en_q),
		.lookup             (lookup),
		.hit_slot           (hit_slot),
		.cache_slot         (cache_slot),
		.upd                (upd),
		.result             (result)
	);

endmodule
`default_nettype wire

// ----- rtl/adrd_checker.sv -----
`default_nettype none
`include "address_range_decoder_with_fault_latch_defines.svh"
module adrd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [47:0] m_axis_tdata
);
	import adrd_pkg::*;

	// stalled result beat holds
	`ADRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	// status stays within the defined codes
	`ADRD_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tdata[3:0] <= ST_CLEARED, "undefined status code")

	// a raised fault only comes with an unmapped access
	`ADRD_ASSERT_NOW(a_fault_unmapped, m_axis_tvalid && m_axis_tdata[12], m_axis_tdata[3:0] == ST_UNMAPPED, "fault raised without unmapped status")

	// a target is only reported on a hit
	`ADRD_ASSERT_NOW(a_target_hit, m_axis_tvalid && m_axis_tdata[11:4] != 8'd0, m_axis_tdata[3:0] == ST_HIT, "target reported without hit")

	// fault fields are only filled when a fault is taken
	`ADRD_ASSERT_NOW(a_fault_fields, m_axis_tvalid && (m_axis_tdata[44:13] != 32'd0 || m_axis_tdata[45]), m_axis_tdata[3:0] == ST_TAKEN, "fault fields set outside take fault")

endmodule

bind address_range_decoder_with_fault_latch adrd_checker u_adrd_checker (.*);
`default_nettype wire
